// ===== rtl/pidl_pkg.sv =====
// Shared types and codes for the positional insert/delete list.
// Used by the list cell and by the top level; no dependencies.
package pidl_pkg;

  // Operation codes carried on opcode.
  localparam logic [2:0] OP_INS_HEAD = 3'd0;
  localparam logic [2:0] OP_INS_TAIL = 3'd1;
  localparam logic [2:0] OP_INS_POS  = 3'd2;
  localparam logic [2:0] OP_DEL_HEAD = 3'd3;
  localparam logic [2:0] OP_DEL_TAIL = 3'd4;
  localparam logic [2:0] OP_DEL_POS  = 3'd5;
  localparam logic [2:0] OP_READ_POS = 3'd6;

  // Status codes returned with every result beat.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_POS_ZERO   = 3'd3;
  localparam logic [2:0] ST_POS_BEYOND = 3'd4;

  // Width of the reported entry count.
  localparam int COUNT_OUT_WIDTH = 7;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;   // open a slot at idx, cells above take from the left
    logic del;   // close the slot at idx, cells from idx take from the right
    logic take;  // copy the word at idx onto the read tree
  } cell_cmd_t;

  // Per-beat result fields that travel alongside the read tree.
  typedef struct packed {
    logic [2:0]                 status;
    logic [COUNT_OUT_WIDTH-1:0] count;
  } meta_t;

endpackage

// ===== rtl/pidl_cell.sv =====
// One storage cell of the list chain: holds one word and trades it with its
// neighbors on insert and delete. Depends on pidl_pkg.
module pidl_cell
  import pidl_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_WIDTH  = 6,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [IDX_WIDTH-1:0]  idx,
  input  logic [DATA_WIDTH-1:0] new_value,
  input  logic [DATA_WIDTH-1:0] left_value,
  input  logic [DATA_WIDTH-1:0] right_value,
  output logic [DATA_WIDTH-1:0] value,
  output logic [DATA_WIDTH-1:0] tap
);

  localparam logic [IDX_WIDTH-1:0] MY_IDX = IDX_WIDTH'(IDX);

  // Shift, load or hold the stored word; drive the tap only when selected.
  always_ff @(posedge clk) begin
    priority if (cmd.ins && (MY_IDX > idx)) begin
      value <= left_value;
    end else if (cmd.ins && (MY_IDX == idx)) begin
      value <= new_value;
    end else if (cmd.del && (MY_IDX >= idx)) begin
      value <= right_value;
    end else begin
      value <= value;
    end
    tap <= (cmd.take && (MY_IDX == idx)) ? value : '0;
  end

endmodule

// ===== rtl/pidl_or_tree.sv =====
// Registered OR tree that gathers the one selected cell tap into a single
// word, with a register at every tree level. No package dependencies.
module pidl_or_tree #(
  parameter int DATA_WIDTH = 32,
  parameter int LEAVES     = 64
) (
  input  logic                  clk,
  input  logic [DATA_WIDTH-1:0] leaf_in [LEAVES],
  output logic [DATA_WIDTH-1:0] root
);

  localparam int LEVELS = $clog2(LEAVES);
  localparam int PAD    = 1 << LEVELS;

  logic [DATA_WIDTH-1:0] leaf [PAD];
  logic [DATA_WIDTH-1:0] node [1:PAD-1];

  // Pad the leaf row up to a power of two with zeros.
  for (genvar j = 0; j < PAD; j++) begin : g_leaf
    if (j < LEAVES) begin : g_used
      assign leaf[j] = leaf_in[j];
    end else begin : g_pad
      assign leaf[j] = '0;
    end
  end

  // Combine pairs, one register per node.
  for (genvar i = 1; i < PAD; i++) begin : g_node
    if (2 * i >= PAD) begin : g_bottom
      always_ff @(posedge clk) begin
        node[i] <= leaf[2*i-PAD] | leaf[2*i+1-PAD];
      end
    end else begin : g_upper
      always_ff @(posedge clk) begin
        node[i] <= node[2*i] | node[2*i+1];
      end
    end
  end

  assign root = node[1];

endmodule

// ===== rtl/positional_insert_delete_list.sv =====
// Top level of the bounded positional list: decode, count, cell chain and
// read tree. Depends on pidl_pkg, pidl_cell and pidl_or_tree.
//
//   channel  | handshake    | fields
//   ---------+--------------+-----------------------------------
//   command  | start, busy  | opcode, item_value, position
//   result   | done         | status, out_value, entry_count
//
// A command beat is taken at every edge where start is high; busy stays low,
// so one command per cycle is sustained.
// Each beat's result shows on done in order, once the word has passed the cell
// tap register and the registered OR tree that gathers the removed or read
// word from the cell chain.
// The chain shifts the affected entries at the accepting edge, so a following
// command already sees the updated list.
// rst (synchronous) clears the count and the result valid pipeline only; stored
// words, result fields and tree registers are left as they are. The result side cannot stall.
module positional_insert_delete_list
  import pidl_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] item_value,
  input  logic [7:0]         position,
  output logic               done,
  output logic [2:0]         status,
  output logic signed [31:0] out_value,
  output logic [6:0]         entry_count
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int IW     = $clog2(CAPACITY);
  localparam int PW     = ((CW > 8) ? CW : 8) + 1;
  localparam int LEVELS = $clog2(CAPACITY);

  logic                  accept;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [PW-1:0]         pos_w;
  logic [PW-1:0]         cnt_w;
  logic                  full;
  logic                  empty;
  logic [2:0]            status_c;
  cell_cmd_t             cmd_c;
  cell_cmd_t             cell_cmd;
  logic [IW-1:0]         op_idx;
  logic [DATA_WIDTH-1:0] ins_word;
  logic [DATA_WIDTH-1:0] value [CAPACITY];
  logic [DATA_WIDTH-1:0] tap   [CAPACITY];
  logic [DATA_WIDTH-1:0] root;
  meta_t                 meta_pipe  [LEVELS+1];
  logic                  valid_pipe [LEVELS+1];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign pos_w    = PW'(position);
  assign cnt_w    = PW'(count);
  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);
  assign ins_word = DATA_WIDTH'(item_value);

  // Check the command against the count and pick the cell index.
  always_comb begin
    status_c = ST_OK;
    cmd_c    = '0;
    op_idx   = '0;
    unique case (opcode)
      OP_INS_HEAD, OP_INS_TAIL: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          cmd_c.ins = 1'b1;
          op_idx    = (opcode == OP_INS_HEAD) ? '0 : IW'(count);
        end
      end
      OP_INS_POS: begin
        priority if (pos_w == '0) begin
          status_c = ST_POS_ZERO;
        end else if (full) begin
          status_c = ST_FULL;
        end else if (pos_w > (cnt_w + 1'b1)) begin
          status_c = ST_POS_BEYOND;
        end else begin
          cmd_c.ins = 1'b1;
          op_idx    = IW'(pos_w - 1'b1);
        end
      end
      OP_DEL_HEAD, OP_DEL_TAIL: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else begin
          cmd_c.del  = 1'b1;
          cmd_c.take = 1'b1;
          op_idx     = (opcode == OP_DEL_HEAD) ? '0 : IW'(count - 1'b1);
        end
      end
      OP_DEL_POS, OP_READ_POS: begin
        priority if (empty) begin
          status_c = ST_EMPTY;
        end else if (pos_w == '0) begin
          status_c = ST_POS_ZERO;
        end else if (pos_w > cnt_w) begin
          status_c = ST_POS_BEYOND;
        end else begin
          cmd_c.del  = (opcode == OP_DEL_POS);
          cmd_c.take = 1'b1;
          op_idx     = IW'(pos_w - 1'b1);
        end
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  // Gate the cell command with acceptance and work out the new count.
  always_comb begin
    cell_cmd = accept ? cmd_c : '0;
    priority if (cell_cmd.ins) begin
      count_next = count + 1'b1;
    end else if (cell_cmd.del) begin
      count_next = count - 1'b1;
    end else begin
      count_next = count;
    end
  end

  // Hold the entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Cell chain, one word per cell.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_v;
    logic [DATA_WIDTH-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_left
      assign left_v = value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_right
      assign right_v = value[i+1];
    end
    pidl_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_WIDTH  (IW),
      .IDX        (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cell_cmd),
      .idx         (op_idx),
      .new_value   (ins_word),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (value[i]),
      .tap         (tap[i])
    );
  end

  // Gather the selected word.
  pidl_or_tree #(
    .DATA_WIDTH (DATA_WIDTH),
    .LEAVES     (CAPACITY)
  ) u_tree (
    .clk     (clk),
    .leaf_in (tap),
    .root    (root)
  );

  // Advance status and count in step with the tree levels.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LEVELS; k++) begin
        valid_pipe[k] <= 1'b0;
      end
    end else begin
      valid_pipe[0] <= accept;
      for (int k = 1; k <= LEVELS; k++) begin
        valid_pipe[k] <= valid_pipe[k-1];
      end
    end
    meta_pipe[0].status <= status_c;
    meta_pipe[0].count  <= COUNT_OUT_WIDTH'(count_next);
    for (int k = 1; k <= LEVELS; k++) begin
      meta_pipe[k] <= meta_pipe[k-1];
    end
  end

  // Present the result beat; an unselected tree reads as zero.
  assign done        = valid_pipe[LEVELS];
  assign status      = meta_pipe[LEVELS].status;
  assign entry_count = meta_pipe[LEVELS].count;
  assign out_value   = 32'($signed(root));

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cell_cmd.ins && cell_cmd.del))
    else $error("insert and delete issued together");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    cell_cmd.ins |=> (count == CW'($past(count) + 1'b1)))
    else $error("insert did not raise the count");

  a_del_count: assert property (@(posedge clk) disable iff (rst)
    cell_cmd.del |=> (count == CW'($past(count) - 1'b1)))
    else $error("delete did not lower the count");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> (out_value == '0))
    else $error("failed beat carries a nonzero word");
`endif

endmodule
